// ===== src/lbp_pkg.sv =====
// Shared constants and types for the 3x3 local binary pattern stream.
`timescale 1ns / 1ps

package lbp_pkg;

    // Geometry limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    // Field and counter widths
    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int LW_W   = 12;
    localparam int FH_W   = 13;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_LINE_WIDTH   = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_FRAME_HEIGHT = 3'd4;

    // Register reset values
    localparam logic [LW_W-1:0] LW_RESET = 12'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;

    // Line buffer entry: older row in the low byte, newer row in the high byte
    typedef struct packed {
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] top;
    } t_lb_entry;

    // Line buffer access request
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
    } t_lb_req;

endpackage

// ===== src/lbp_3x3_code_stream.sv =====
// Top level: 3x3 local binary pattern codes over a raster pixel stream.
//
//  channel  | direction | signals                                  | payload
//  ---------+-----------+------------------------------------------+------------------------
//  s        | in        | i_s_tvalid, o_s_tready, i_s_tdata/tuser  | pixel, frame_start
//  m        | out       | o_m_tvalid, i_m_tready, o_m_tdata/tlast  | lbp_code, frame_last
//  apb      | cfg       | i_psel, i_penable, i_pwrite, i_paddr ... | line_width, frame_height
//
// One pixel per clock is accepted unless an output stall holds it. A code passes the
// pixel stage, which waits for the registered line buffer RAM read (separate read and
// write ports), then the output register. Reset clears counters, window and handshake
// state; the line buffer RAM is not cleared. A stall on the output holds the pixel stage
// and drops tready only when both the pixel stage and output register are full.
`timescale 1ns / 1ps

module lbp_3x3_code_stream
    import lbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Pixel input
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] pixel
    input  logic              i_s_tuser,   // [0] frame_start
    // Code output
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // [7:0] lbp_code
    output logic              o_m_tlast,   // frame_last
    // Configuration
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output logic [DATA_W-1:0] o_prdata,
    output logic              o_pready
);

    // Configuration registers
    logic [LW_W-1:0] r_line_width;
    logic [FH_W-1:0] r_frame_height;
    logic            cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LW_RESET;
            r_frame_height <= FH_RESET;
        end else if (cfg_wr) begin
            if (i_paddr == ADDR_LINE_WIDTH) begin
                r_line_width <= i_pwdata[LW_W-1:0];
            end
            if (i_paddr == ADDR_FRAME_HEIGHT) begin
                r_frame_height <= i_pwdata[FH_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (i_paddr)
            ADDR_LINE_WIDTH:   o_prdata = {{(DATA_W-LW_W){1'b0}}, r_line_width};
            ADDR_FRAME_HEIGHT: o_prdata = {{(DATA_W-FH_W){1'b0}}, r_frame_height};
            default:           o_prdata = '0;
        endcase
    end

    // Clamp geometry to the supported range
    localparam logic [LW_W-1:0] W_MIN = LW_W'(3);
    localparam logic [LW_W-1:0] W_MAX = LW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] H_MIN = FH_W'(3);
    localparam logic [FH_W-1:0] H_MAX = FH_W'(MAX_HEIGHT);

    logic [LW_W-1:0] w_eff;
    logic [FH_W-1:0] h_eff;

    always_comb begin
        if (r_line_width < W_MIN) begin
            w_eff = W_MIN;
        end else if (r_line_width > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = r_line_width;
        end
        if (r_frame_height < H_MIN) begin
            h_eff = H_MIN;
        end else if (r_frame_height > H_MAX) begin
            h_eff = H_MAX;
        end else begin
            h_eff = r_frame_height;
        end
    end

    // Handshake and stage control
    logic s_acc;
    logic s1_go;
    logic s1_emit;
    logic r_v1;
    logic r_ov;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_v1 || s1_go;
    assign o_m_tvalid = r_ov;

    // Position of the incoming pixel
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] c_in;
    logic [ROW_W-1:0] r_in;
    logic [LW_W-1:0]  c_in_p1;
    logic [FH_W-1:0]  r_in_p1;

    assign c_in    = i_s_tuser ? '0 : r_col;
    assign r_in    = i_s_tuser ? '0 : r_row;
    assign c_in_p1 = LW_W'(c_in) + LW_W'(1);
    assign r_in_p1 = FH_W'(r_in) + FH_W'(1);

    // Advance column and row on each accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_acc) begin
            if (c_in_p1 >= w_eff) begin
                r_col <= '0;
                r_row <= (r_in_p1 >= h_eff) ? '0 : r_in_p1[ROW_W-1:0];
            end else begin
                r_col <= c_in_p1[COL_W-1:0];
                r_row <= r_in;
            end
        end
    end

    // Pixel stage: pixel and position wait for the line buffer read
    logic [PIX_W-1:0] r_px1;
    logic [COL_W-1:0] r_c1;
    logic [ROW_W-1:0] r_r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_acc) begin
            r_v1 <= 1'b1;
        end else if (s1_go) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_px1 <= i_s_tdata;
            r_c1  <= c_in;
            r_r1  <= r_in;
        end
    end

    // Line buffer
    t_lb_req   lb_req;
    t_lb_entry lb_rd;
    t_lb_entry lb_wr;

    assign lb_req.rd_en   = s_acc;
    assign lb_req.rd_addr = c_in;
    assign lb_req.wr_en   = s1_go;
    assign lb_req.wr_addr = r_c1;
    assign lb_wr.top      = lb_rd.mid;
    assign lb_wr.mid      = r_px1;

    lbp_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (lb_req),
        .i_wr_data (lb_wr),
        .o_rd_data (lb_rd)
    );

    // Window: left and middle columns, rows top to bottom
    logic [PIX_W-1:0] r_win [6];
    logic [PIX_W-1:0] ctr;
    logic [7:0]       code;
    logic             last;

    assign ctr     = r_win[4];
    assign s1_emit = (r_r1 >= ROW_W'(2)) && (r_c1 >= COL_W'(2));
    assign s1_go   = r_v1 && (!s1_emit || !r_ov || i_m_tready);

    // Compare neighbors against the center, clockwise from top-left
    always_comb begin
        code[7] = r_win[0]  >= ctr;
        code[6] = r_win[3]  >= ctr;
        code[5] = lb_rd.top >= ctr;
        code[4] = lb_rd.mid >= ctr;
        code[3] = r_px1     >= ctr;
        code[2] = r_win[5]  >= ctr;
        code[1] = r_win[2]  >= ctr;
        code[0] = r_win[1]  >= ctr;
        last    = (FH_W'(r_r1) + FH_W'(1) == h_eff) && (LW_W'(r_c1) + LW_W'(1) == w_eff);
    end

    // Shift the window as the pixel stage retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_go) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= lb_rd.top;
            r_win[4] <= lb_rd.mid;
            r_win[5] <= r_px1;
        end
    end

    // Output register
    logic [7:0] r_code;
    logic       r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s1_go && s1_emit) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emit) begin
            r_code <= code;
            r_last <= last;
        end
    end

    assign o_m_tdata = r_code;
    assign o_m_tlast = r_last;

endmodule

// ===== src/lbp_line_buf.sv =====
// Two-row line buffer memory with registered read and write-to-read forwarding.
`timescale 1ns / 1ps

module lbp_line_buf
    import lbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lb_req   i_req,
    input  t_lb_entry i_wr_data,
    output t_lb_entry o_rd_data
);

    t_lb_entry r_mem [MAX_WIDTH];
    t_lb_entry r_q;
    t_lb_entry r_fwd_data;
    logic      r_fwd;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
    end

    // Catch a read of the entry written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_req.rd_en) begin
            r_fwd <= i_req.wr_en && (i_req.wr_addr == i_req.rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule
